>>> hdl/rpbs_pkg.sv
package rpbs_pkg;

   localparam int TERMS_DEF = 64;

   localparam int PH_W   = 24;
   localparam int FAC_W  = 18;
   localparam int PROD_W = PH_W + FAC_W;
   localparam int SUM_W  = 30;
   localparam int TICK_W = 32;
   localparam int CFG_W  = 7;
   localparam int IDX_W  = 6;
   localparam int ACT_W  = 2;

   localparam int REQ_DATA_W = 96;
   localparam int REQ_USER_W = ACT_W;
   localparam int RSP_DATA_W = 96;

   localparam logic [ACT_W-1:0] ACT_LOAD = 2'd0;
   localparam logic [ACT_W-1:0] ACT_TICK = 2'd1;
   localparam logic [ACT_W-1:0] ACT_PEEK = 2'd2;

   localparam int PH_MAX  = 2**(PH_W-1) - 1;
   localparam int PH_MIN  = -(2**(PH_W-1));
   localparam int SUM_MAX = 2**(SUM_W-1) - 1;
   localparam int SUM_MIN = -(2**(SUM_W-1));

   // One stored entry: phasor value and its per-tick rotation factor.
   typedef struct packed {
      logic signed [FAC_W-1:0] fim;
      logic signed [FAC_W-1:0] fre;
      logic signed [PH_W-1:0]  im;
      logic signed [PH_W-1:0]  re;
   } rpbs_entry_type;

   typedef struct packed {
      logic valid;
      logic rotate;
   } rpbs_ctl_type;

endpackage

>>> hdl/rpbs_ram.sv
module rpbs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/rpbs_rot.sv
module rpbs_rot #(
   parameter int AW = 6
) (
   input  logic                     clock,
   input  logic                     reset,
   input  rpbs_pkg::rpbs_ctl_type   in_ctl,
   input  logic [AW-1:0]            in_addr,
   input  rpbs_pkg::rpbs_entry_type in_entry,
   output rpbs_pkg::rpbs_ctl_type   out_ctl,
   output logic [AW-1:0]            out_addr,
   output rpbs_pkg::rpbs_entry_type out_entry,
   output logic                     busy
);

   import rpbs_pkg::*;

   localparam int RND_W = PROD_W + 2;
   localparam int SHR_W = RND_W - 16;

   // Round half toward +infinity from Q.32 to Q.16, then saturate to the phasor width.
   function automatic logic signed [PH_W-1:0] rnd_sat(input logic signed [RND_W-1:0] v);
      logic signed [RND_W-1:0] biased;
      logic signed [SHR_W-1:0] shr;
      biased = v + RND_W'(32768);
      shr    = SHR_W'(biased >>> 16);
      if (shr > SHR_W'(PH_MAX)) begin
         rnd_sat = PH_W'(PH_MAX);
      end else if (shr < SHR_W'(PH_MIN)) begin
         rnd_sat = PH_W'(PH_MIN);
      end else begin
         rnd_sat = PH_W'(shr);
      end
   endfunction

   rpbs_ctl_type             a_ctl_ff, a_ctl_in;
   logic [AW-1:0]            a_addr_ff;
   rpbs_entry_type           a_entry_ff;
   logic signed [PROD_W-1:0] a_rr_ff, a_ii_ff, a_ri_ff, a_ir_ff;
   logic signed [PROD_W-1:0] a_rr_in, a_ii_in, a_ri_in, a_ir_in;

   rpbs_ctl_type             b_ctl_ff, b_ctl_in;
   logic [AW-1:0]            b_addr_ff;
   rpbs_entry_type           b_entry_ff, b_entry_in;

   // First stage: the four partial products of the complex multiply.
   assign a_ctl_in = in_ctl;
   assign a_rr_in  = in_entry.re * in_entry.fre;
   assign a_ii_in  = in_entry.im * in_entry.fim;
   assign a_ri_in  = in_entry.re * in_entry.fim;
   assign a_ir_in  = in_entry.im * in_entry.fre;

   // Second stage: combine, round and saturate; a peek passes the phasor through.
   always_comb begin
      b_ctl_in   = a_ctl_ff;
      b_entry_in = a_entry_ff;
      if (a_ctl_ff.rotate) begin
         b_entry_in.re = rnd_sat(RND_W'(a_rr_ff) - RND_W'(a_ii_ff));
         b_entry_in.im = rnd_sat(RND_W'(a_ri_ff) + RND_W'(a_ir_ff));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ctl_ff <= '0;
         b_ctl_ff <= '0;
      end else begin
         a_ctl_ff <= a_ctl_in;
         b_ctl_ff <= b_ctl_in;
      end
      a_addr_ff  <= in_addr;
      a_entry_ff <= in_entry;
      a_rr_ff    <= a_rr_in;
      a_ii_ff    <= a_ii_in;
      a_ri_ff    <= a_ri_in;
      a_ir_ff    <= a_ir_in;
      b_addr_ff  <= a_addr_ff;
      b_entry_ff <= b_entry_in;
   end

   assign out_ctl   = b_ctl_ff;
   assign out_addr  = b_addr_ff;
   assign out_entry = b_entry_ff;
   assign busy      = a_ctl_ff.valid | b_ctl_ff.valid;

endmodule

>>> hdl/rotating_phasor_bank_sum_core.sv
// Bank of rotating complex phasors with a summed output.
//
// Requests arrive on req_* and are accepted when req_tvalid and req_tready are
// both high. req_tuser carries the action: load writes one entry's phasor and
// rotation factor, tick rotates every active entry and then reports the sum,
// peek reports the sum without rotating. Any other action is dropped silently.
// Results leave on rsp_* as a registered output that holds while rsp_tready is
// low. csr_wr_en writes term_count, the number of active entries from entry 0.
//
// A load writes its entry as it is accepted. A tick or peek walks the active
// entries through one memory read port and one complex multiplier at one entry
// per cycle, and the next request is taken once the sum has been loaded into
// the output register. A stalled receiver holds the result and, if a second
// sum is ready before the first is taken, holds back that sum and all further
// requests.
//
// After reset a clearing pass zeroes the entry memory with req_tready low;
// term_count and the tick counter reset to zero.
module rotating_phasor_bank_sum_core #(
   parameter int TERMS = rpbs_pkg::TERMS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [rpbs_pkg::CFG_W-1:0]      csr_wr_data,    // term_count
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // entry_index, entry_re, entry_im, rot_re, rot_im, zero pad
   input  logic [rpbs_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic [rpbs_pkg::REQ_USER_W-1:0] req_tuser,      // action
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // sum_re, sum_im, tick_number, zero pad
   output logic [rpbs_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   import rpbs_pkg::*;

   localparam int AW    = (TERMS > 1) ? $clog2(TERMS) : 1;
   localparam int CNT_W = $clog2(TERMS + 1);
   localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
   localparam int ACC_W = PH_W + CNT_W;
   localparam int SAT_W = (ACC_W > SUM_W) ? ACC_W : SUM_W;
   localparam int PAD_W = RSP_DATA_W - 2 * SUM_W - TICK_W;

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_ISSUE  = 3'd2;
   localparam logic [2:0] ST_DRAIN  = 3'd3;
   localparam logic [2:0] ST_FINISH = 3'd4;

   logic [2:0]                state_ff, state_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic [CNT_W-1:0]          n_ff, n_in;
   logic                      rotate_ff, rotate_in;
   logic [CFG_W-1:0]          term_count_ff;
   logic [TICK_W-1:0]         ticks_ff, ticks_in;
   logic signed [ACC_W-1:0]   acc_re_ff, acc_re_in, acc_im_ff, acc_im_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]     rsp_data_ff, rsp_data_in;
   rpbs_ctl_type              s1_ctl_ff, s1_ctl_in;
   logic [AW-1:0]             s1_addr_ff;

   logic                      req_acc;
   logic [ACT_W-1:0]          req_action;
   logic [IDX_W-1:0]          req_index;
   rpbs_entry_type            req_entry;
   logic [CMP_W-1:0]          n_cmp;

   logic                      wr_en;
   logic [AW-1:0]             wr_addr;
   rpbs_entry_type            wr_data;
   logic [AW-1:0]             rd_addr;
   rpbs_entry_type            rd_data;

   rpbs_ctl_type              rot_ctl;
   logic [AW-1:0]             rot_addr;
   rpbs_entry_type            rot_entry;
   logic                      rot_busy;

   logic signed [SAT_W-1:0]   sat_re_ext, sat_im_ext;
   logic [SUM_W-1:0]          sum_re, sum_im;

   assign req_action   = req_tuser[ACT_W-1:0];
   assign req_index    = req_tdata[5:0];
   assign req_entry.re  = req_tdata[29:6];
   assign req_entry.im  = req_tdata[53:30];
   assign req_entry.fre = req_tdata[71:54];
   assign req_entry.fim = req_tdata[89:72];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid & req_tready;

   assign n_cmp = (CMP_W'(term_count_ff) > CMP_W'(TERMS)) ? CMP_W'(TERMS)
                                                           : CMP_W'(term_count_ff);
   assign n_in  = CNT_W'(n_cmp);

   assign rd_addr = cnt_ff[AW-1:0];

   rpbs_ram #(
      .WIDTH ($bits(rpbs_entry_type)),
      .DEPTH (TERMS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   rpbs_rot #(
      .AW (AW)
   ) u_rot (
      .clock     (clock),
      .reset     (reset),
      .in_ctl    (s1_ctl_ff),
      .in_addr   (s1_addr_ff),
      .in_entry  (rd_data),
      .out_ctl   (rot_ctl),
      .out_addr  (rot_addr),
      .out_entry (rot_entry),
      .busy      (rot_busy)
   );

   // Saturate the exact sums to the output width.
   assign sat_re_ext = SAT_W'(acc_re_ff);
   assign sat_im_ext = SAT_W'(acc_im_ff);
   always_comb begin
      if (sat_re_ext > SAT_W'(SUM_MAX)) begin
         sum_re = SUM_W'(SUM_MAX);
      end else if (sat_re_ext < SAT_W'(SUM_MIN)) begin
         sum_re = SUM_W'(SUM_MIN);
      end else begin
         sum_re = sat_re_ext[SUM_W-1:0];
      end
      if (sat_im_ext > SAT_W'(SUM_MAX)) begin
         sum_im = SUM_W'(SUM_MAX);
      end else if (sat_im_ext < SAT_W'(SUM_MIN)) begin
         sum_im = SUM_W'(SUM_MIN);
      end else begin
         sum_im = sat_im_ext[SUM_W-1:0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rotate_in    = rotate_ff;
      ticks_in     = ticks_ff;
      acc_re_in    = acc_re_ff;
      acc_im_in    = acc_im_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      s1_ctl_in    = '0;
      wr_en        = 1'b0;
      wr_addr      = rot_addr;
      wr_data      = rot_entry;

      // Rotated entries are written back and every entry coming out is summed.
      if (rot_ctl.valid) begin
         wr_en     = rot_ctl.rotate;
         acc_re_in = acc_re_ff + ACC_W'(rot_entry.re);
         acc_im_in = acc_im_ff + ACC_W'(rot_entry.im);
      end

      unique case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = cnt_ff[AW-1:0];
            wr_data = '0;
            cnt_in  = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(TERMS - 1)) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_acc) begin
               cnt_in    = '0;
               acc_re_in = '0;
               acc_im_in = '0;
               case (req_action)
                  ACT_LOAD: begin
                     wr_en   = (CMP_W'(req_index) < CMP_W'(TERMS));
                     wr_addr = AW'(req_index);
                     wr_data = req_entry;
                  end
                  ACT_TICK: begin
                     ticks_in  = ticks_ff + TICK_W'(1);
                     rotate_in = 1'b1;
                     state_in  = ST_ISSUE;
                  end
                  ACT_PEEK: begin
                     rotate_in = 1'b0;
                     state_in  = ST_ISSUE;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_ISSUE: begin
            if (cnt_ff == n_ff) begin
               state_in = ST_DRAIN;
            end else begin
               s1_ctl_in.valid  = 1'b1;
               s1_ctl_in.rotate = rotate_ff;
               cnt_in           = cnt_ff + CNT_W'(1);
            end
         end
         ST_DRAIN: begin
            if (!s1_ctl_ff.valid && !rot_busy) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {PAD_W'(0), ticks_ff, sum_im, sum_re};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         cnt_ff        <= '0;
         n_ff          <= '0;
         rotate_ff     <= 1'b0;
         term_count_ff <= '0;
         ticks_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         s1_ctl_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rotate_ff    <= rotate_in;
         ticks_ff     <= ticks_in;
         rsp_valid_ff <= rsp_valid_in;
         s1_ctl_ff    <= s1_ctl_in;
         if (req_acc) begin
            n_ff <= n_in;
         end
         if (csr_wr_en) begin
            term_count_ff <= csr_wr_data;
         end
      end
      s1_addr_ff  <= rd_addr;
      acc_re_ff   <= acc_re_in;
      acc_im_ff   <= acc_im_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

>>> hdl/rpbs_checker.sv
module rpbs_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [rpbs_pkg::REQ_USER_W-1:0] req_tuser,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [rpbs_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   import rpbs_pkg::*;

   // No result survives a reset.
   a_reset_clears: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

   // A stalled result holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // A tick or peek keeps the block busy for at least the next cycle.
   a_sum_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == ACT_TICK || req_tuser == ACT_PEEK)
      |=> !req_tready)
      else $error("request taken while a sum was in progress");

   // A load never produces a result.
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == ACT_LOAD && !rsp_tvalid
      |=> !rsp_tvalid)
      else $error("result appeared after a load");

endmodule

bind rotating_phasor_bank_sum_core rpbs_checker u_rpbs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

>>> verif/tb_rotating_phasor_bank_sum_core.sv
module tb_rotating_phasor_bank_sum_core;
   timeunit 1ns;
   timeprecision 1ps;

   import rpbs_pkg::*;

   localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES  = TERMS_DEF + 16;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int REPORT_LIMIT   = 10;
   localparam int FAC_ONE        = 65536;

   typedef struct {
      logic [ACT_W-1:0]        action;
      logic [IDX_W-1:0]        idx;
      logic signed [PH_W-1:0]  ph_re;
      logic signed [PH_W-1:0]  ph_im;
      logic signed [FAC_W-1:0] fac_re;
      logic signed [FAC_W-1:0] fac_im;
   } bank_req_type;

   typedef struct {
      logic signed [SUM_W-1:0] sum_re;
      logic signed [SUM_W-1:0] sum_im;
      logic [TICK_W-1:0]       ticks;
   } bank_sum_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_wr_en = 1'b0;
   logic [CFG_W-1:0]      csr_wr_data = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [REQ_USER_W-1:0] req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   // Shadow copy of the phasor bank, kept in step with accepted requests.
   logic signed [PH_W-1:0]  bank_re [TERMS_DEF];
   logic signed [PH_W-1:0]  bank_im [TERMS_DEF];
   logic signed [FAC_W-1:0] rot_re  [TERMS_DEF];
   logic signed [FAC_W-1:0] rot_im  [TERMS_DEF];
   logic [TICK_W-1:0]       tick_count = '0;
   int                      active_terms = 0;

   bank_req_type req_backlog [$];
   bank_req_type req_on_bus;
   bank_sum_type expected_sums [$];

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int fail_count     = 0;
   int mismatch_count = 0;
   int quiet_cycles   = 0;

   rotating_phasor_bank_sum_core #(
      .TERMS(TERMS_DEF)
   ) uut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      for (int i = 0; i < TERMS_DEF; i++) begin
         bank_re[i] = '0;
         bank_im[i] = '0;
         rot_re[i]  = '0;
         rot_im[i]  = '0;
      end
   end

   function automatic logic signed [PH_W-1:0] round_rotated(longint v);
      longint r;
      r = (v + 64'sd32768) >>> 16;
      if (r > PH_MAX) begin
         r = PH_MAX;
      end else if (r < PH_MIN) begin
         r = PH_MIN;
      end
      return r[PH_W-1:0];
   endfunction

   function automatic logic signed [SUM_W-1:0] clamp_sum(longint v);
      if (v > SUM_MAX) begin
         v = SUM_MAX;
      end else if (v < SUM_MIN) begin
         v = SUM_MIN;
      end
      return v[SUM_W-1:0];
   endfunction

   // Updates the shadow bank for one accepted request and queues its sum.
   function automatic void apply_request(bank_req_type r);
      int n;
      longint pr, pi, fr, fi, acc_re, acc_im;
      bank_sum_type res;
      n = (active_terms > TERMS_DEF) ? TERMS_DEF : active_terms;
      if (r.action == ACT_LOAD) begin
         bank_re[r.idx] = r.ph_re;
         bank_im[r.idx] = r.ph_im;
         rot_re[r.idx]  = r.fac_re;
         rot_im[r.idx]  = r.fac_im;
         return;
      end
      if (r.action != ACT_TICK && r.action != ACT_PEEK) return;
      if (r.action == ACT_TICK) begin
         tick_count = tick_count + 1;
         for (int i = 0; i < n; i++) begin
            pr = bank_re[i];
            pi = bank_im[i];
            fr = rot_re[i];
            fi = rot_im[i];
            bank_re[i] = round_rotated(pr * fr - pi * fi);
            bank_im[i] = round_rotated(pr * fi + pi * fr);
         end
      end
      acc_re = 0;
      acc_im = 0;
      for (int i = 0; i < n; i++) begin
         acc_re += bank_re[i];
         acc_im += bank_im[i];
      end
      res.sum_re = clamp_sum(acc_re);
      res.sum_im = clamp_sum(acc_im);
      res.ticks  = tick_count;
      expected_sums.push_back(res);
   endfunction

   function automatic bank_req_type make_req(logic [ACT_W-1:0] act, int idx, int pre, int pim,
                                             int fre, int fim);
      bank_req_type r;
      r.action = act;
      r.idx    = idx[IDX_W-1:0];
      r.ph_re  = pre[PH_W-1:0];
      r.ph_im  = pim[PH_W-1:0];
      r.fac_re = fre[FAC_W-1:0];
      r.fac_im = fim[FAC_W-1:0];
      return r;
   endfunction

   function automatic int pick_phasor();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 4) return int'($urandom);
      if (sel == 4) return PH_MAX;
      if (sel == 5) return PH_MIN;
      if (sel == 6) return 0;
      return $urandom_range(0, 2097152) - 1048576;
   endfunction

   // Mostly near-unit factors so that the bank stays lively over many ticks.
   function automatic int pick_factor();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 3) return int'($urandom);
      if (sel == 3) return 131071;
      if (sel == 4) return -131072;
      if (sel == 5) return $urandom_range(0, 1) ? FAC_ONE : -FAC_ONE;
      return $urandom_range(0, 2 * FAC_ONE) - FAC_ONE;
   endfunction

   function automatic bank_req_type random_req(int active);
      int sel, idx, span;
      logic [ACT_W-1:0] act;
      sel = $urandom_range(0, 99);
      if (sel < 45) begin
         act = ACT_LOAD;
      end else if (sel < 80) begin
         act = ACT_TICK;
      end else if (sel < 95) begin
         act = ACT_PEEK;
      end else begin
         act = ACT_UNUSED;
      end
      span = (active > TERMS_DEF) ? TERMS_DEF : active;
      if (span > 0 && $urandom_range(0, 9) < 7) begin
         idx = $urandom_range(0, span - 1);
      end else begin
         idx = $urandom_range(0, TERMS_DEF - 1);
      end
      return make_req(act, idx, pick_phasor(), pick_phasor(), pick_factor(), pick_factor());
   endfunction

   // Driver: presents the backlog on the request channel.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) apply_request(req_on_bus);
         if (!req_tvalid || req_tready) begin
            if (req_backlog.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_on_bus = req_backlog.pop_front();
               req_tdata  <= {6'b0, req_on_bus.fac_im, req_on_bus.fac_re, req_on_bus.ph_im,
                              req_on_bus.ph_re, req_on_bus.idx};
               req_tuser  <= req_on_bus.action;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks every sum that leaves the block against the oldest prediction.
   always @(posedge clock) begin
      bank_sum_type want;
      bank_sum_type got;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.sum_re = rsp_tdata[SUM_W-1:0];
            got.sum_im = rsp_tdata[2*SUM_W-1:SUM_W];
            got.ticks  = rsp_tdata[2*SUM_W+TICK_W-1:2*SUM_W];
            if (expected_sums.size() == 0) begin
               fail_count++;
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("Unexpected result: re=%0d im=%0d ticks=%0d",
                           got.sum_re, got.sum_im, got.ticks);
            end else begin
               want = expected_sums.pop_front();
               if (got.sum_re !== want.sum_re || got.sum_im !== want.sum_im ||
                   got.ticks !== want.ticks) begin
                  fail_count++;
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT)
                     $display({"Mismatch: expected re=%0d im=%0d ticks=%0d,",
                               " got re=%0d im=%0d ticks=%0d"},
                              want.sum_re, want.sum_im, want.ticks,
                              got.sum_re, got.sum_im, got.ticks);
               end
            end
         end
         rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // Watchdog on cycles in which neither channel moves a request or a result.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic wait_drained(bit settle);
      do @(posedge clock);
      while (req_backlog.size() != 0 || req_tvalid || expected_sums.size() != 0);
      // A trailing load may still be in flight after the last sum came back.
      if (settle) repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_term_count(int value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value[CFG_W-1:0];
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      active_terms = value & 'h7f;
   endtask

   task automatic set_idling(int mode);
      case (mode % 4)
         0: begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
         end
         1: begin
            send_idle_pct  = 78;
            recv_stall_pct = 0;
         end
         2: begin
            send_idle_pct  = 0;
            recv_stall_pct = 78;
         end
         default: begin
            send_idle_pct  = 16;
            recv_stall_pct = 16;
         end
      endcase
   endtask

   initial begin
      int tc_plan [12];
      int batch;
      tc_plan = '{1, 64, 0, 127, 3, 2, 64, 5, 65, 8, 4, 16};
      tc_plan[7]  = $urandom_range(1, 8);
      tc_plan[10] = $urandom_range(0, 127);
      tc_plan[11] = $urandom_range(1, 16);

      reset = 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Empty bank with no active entries: sums stay zero, ticks still count.
      set_idling(0);
      req_backlog.push_back(make_req(ACT_PEEK, 0, 0, 0, 0, 0));
      req_backlog.push_back(make_req(ACT_TICK, 0, 0, 0, 0, 0));
      req_backlog.push_back(make_req(ACT_UNUSED, 5, PH_MAX, PH_MIN, 131071, -131072));
      req_backlog.push_back(make_req(ACT_LOAD, 63, PH_MAX, PH_MAX, 131071, 131071));
      req_backlog.push_back(make_req(ACT_LOAD, 0, PH_MIN, PH_MIN, -131072, -131072));
      wait_drained(1);

      // Full bank: saturating products and rounding ties on both signs.
      write_term_count(TERMS_DEF);
      req_backlog.push_back(make_req(ACT_LOAD, 0, PH_MAX, PH_MAX, 131071, 131071));
      req_backlog.push_back(make_req(ACT_LOAD, 1, PH_MIN, PH_MIN, -131072, -131072));
      req_backlog.push_back(make_req(ACT_LOAD, 2, 1, -1, 32768, 0));
      req_backlog.push_back(make_req(ACT_LOAD, 3, -1, 0, 32768, 32768));
      req_backlog.push_back(make_req(ACT_PEEK, 0, 0, 0, 0, 0));
      req_backlog.push_back(make_req(ACT_TICK, 0, 0, 0, 0, 0));
      req_backlog.push_back(make_req(ACT_TICK, 0, 0, 0, 0, 0));
      req_backlog.push_back(make_req(ACT_PEEK, 0, 0, 0, 0, 0));
      req_backlog.push_back(make_req(ACT_LOAD, 63, 12345, -54321, FAC_ONE, -1));
      req_backlog.push_back(make_req(ACT_UNUSED, 0, 0, 0, 0, 0));
      wait_drained(1);

      // A count above the bank size behaves as the full bank.
      write_term_count(127);
      req_backlog.push_back(make_req(ACT_TICK, 0, 0, 0, 0, 0));
      req_backlog.push_back(make_req(ACT_PEEK, 0, 0, 0, 0, 0));
      wait_drained(1);

      // Only entry 0 active.
      write_term_count(1);
      req_backlog.push_back(make_req(ACT_TICK, 0, 0, 0, 0, 0));
      req_backlog.push_back(make_req(ACT_PEEK, 0, 0, 0, 0, 0));
      wait_drained(1);

      for (int ph = 0; ph < 12; ph++) begin
         write_term_count(tc_plan[ph]);
         set_idling(ph);
         batch = 110;
         if (ph == 2) begin
            // Let the block run completely dry in the middle of the phase.
            for (int k = 0; k < batch / 2; k++) req_backlog.push_back(random_req(active_terms));
            wait_drained(0);
            batch = batch - batch / 2;
         end
         for (int k = 0; k < batch; k++) req_backlog.push_back(random_req(active_terms));
         wait_drained(1);
      end

      if (fail_count == 0 && expected_sums.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
